// ----- hw/rtl/spq_pkg.sv -----
// shared types and constants for the sorted priority queue
`default_nettype none

package spq_pkg;

   localparam int KEY_W   = 32;
   localparam int COUNT_W = 6;
   localparam int COUNT_MAX = 63;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [COUNT_W-1:0]      count_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic ins;
      logic rem;
   } cell_ctl_type;

   localparam key_type KEY_EMPTY = -32'sd1;

endpackage

`default_nettype wire

// ----- hw/rtl/spq_if.sv -----
// request and response channel interfaces of the sorted priority queue
`default_nettype none

interface spq_req_if
   import spq_pkg::*;
   ;
   logic    valid;
   logic    ready;
   op_type  operation;
   key_type key;

   modport source (output valid, output operation, output key, input ready);
   modport sink   (input valid, input operation, input key, output ready);
endinterface

interface spq_rsp_if
   import spq_pkg::*;
   ;
   logic       valid;
   logic       ready;
   key_type    removed_key;
   count_type  compare_count;
   status_type status;

   modport source (output valid, output removed_key, output compare_count, output status,
                   input ready);
   modport sink   (input valid, input removed_key, input compare_count, input status,
                   output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sorted_priority_queue.sv -----
// top level of the sorted priority queue, largest key first
//
// usage
//   req_ch carries one command per transaction: operation insert or remove,
//   and the key to insert (ignored on remove). rsp_ch returns exactly one
//   transaction per command: removed_key, compare_count and status.
//   keys live in a chain of CAPACITY cells, kept in descending order;
//   cell 0 is the front. every cell compares the incoming key with its
//   own in the same cycle and then keeps, takes the new key or takes its
//   neighbor's key, so an insert or remove is one shift of the chain.
// response timing and throughput
//   the response is registered: it appears in the cycle after the request
//   transaction. one transaction per cycle is sustained while responses are
//   taken; the cell compare plus the insertion-point encoder set the cycle.
// reset
//   synchronous reset empties the queue (all cell valid bits cleared) and
//   drops any pending response. cell keys are not cleared.
// stalls
//   while a response waits with rsp_ch.ready low, req_ch.ready drops and no
//   new request is taken; taking the response frees the slot that cycle.
`default_nettype none

module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   spq_req_if.sink    req_ch,
   spq_rsp_if.source  rsp_ch
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int POS_W = $clog2(CAPACITY);

   // request side
   logic         accept;
   logic         full;
   logic         empty;
   cell_ctl_type ctl;

   // cell chain
   key_type               cell_key   [CAPACITY];
   logic [CAPACITY-1:0]   cell_valid;
   logic [CAPACITY-1:0]   cell_le;
   logic [CAPACITY-1:0]   ins_point;

   // insertion point encode
   logic [POS_W-1:0] pos;
   logic [POS_W-1:0] pos_m1;
   count_type        comps;

   // state and response registers
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   key_type          removed_ff, removed_in;
   count_type        comps_ff, comps_in;
   status_type       status_ff, status_in;

   // a new transaction is taken when the response slot is free or draining
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign full  = count_ff == CNT_W'(CAPACITY);
   assign empty = count_ff == '0;

   assign ctl.ins = accept && (req_ch.operation == OP_INSERT) && !full;
   assign ctl.rem = accept && (req_ch.operation == OP_REMOVE) && !empty;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         key_type left_key, right_key;
         logic    left_valid, left_le, right_valid;

         if (gi == 0) begin : g_head
            assign left_key   = '0;
            assign left_valid = 1'b0;
            assign left_le    = 1'b0;
            assign ins_point[gi] = cell_le[gi];
         end else begin : g_mid
            assign left_key   = cell_key[gi-1];
            assign left_valid = cell_valid[gi-1];
            assign left_le    = cell_le[gi-1];
            assign ins_point[gi] = cell_le[gi] && !cell_le[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_tail
            assign right_key   = '0;
            assign right_valid = 1'b0;
         end else begin : g_body
            assign right_key   = cell_key[gi+1];
            assign right_valid = cell_valid[gi+1];
         end

         spq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .new_key     (req_ch.key),
            .front       (gi == 0),
            .left_key    (left_key),
            .left_valid  (left_valid),
            .left_le     (left_le),
            .right_key   (right_key),
            .right_valid (right_valid),
            .key         (cell_key[gi]),
            .valid       (cell_valid[gi]),
            .le          (cell_le[gi])
         );
      end
   endgenerate

   // one-hot insertion point to binary position, plain or-reduction per bit
   always_comb begin
      pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (ins_point[i]) begin
            pos = pos | POS_W'(i);
         end
      end
   end

   // entries passed after the front, saturated to the field
   assign pos_m1 = pos - POS_W'(1);
   always_comb begin
      if (pos == '0) begin
         comps = '0;
      end else if (32'(pos_m1) > 32'(COUNT_MAX)) begin
         comps = COUNT_W'(COUNT_MAX);
      end else begin
         comps = COUNT_W'(pos_m1);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.rem) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // response for the transaction taken this cycle
   always_comb begin
      removed_in = removed_ff;
      comps_in   = comps_ff;
      status_in  = status_ff;
      if (accept) begin
         unique case (req_ch.operation)
            OP_INSERT: begin
               removed_in = '0;
               comps_in   = full ? count_type'(0) : comps;
               status_in  = full ? STATUS_FULL : STATUS_OK;
            end
            OP_REMOVE: begin
               removed_in = empty ? KEY_EMPTY : cell_key[0];
               comps_in   = '0;
               status_in  = empty ? STATUS_EMPTY : STATUS_OK;
            end
            default: begin
               removed_in = '0;
               comps_in   = '0;
               status_in  = STATUS_OK;
            end
         endcase
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      removed_ff <= removed_in;
      comps_ff   <= comps_in;
      status_ff  <= status_in;
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.removed_key   = removed_ff;
   assign rsp_ch.compare_count = comps_ff;
   assign rsp_ch.status        = status_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/spq_cell.sv -----
// one storage cell of the sorted chain: holds a key, compares, shifts
`default_nettype none

module spq_cell
   import spq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_ctl_type ctl,
   input  wire key_type      new_key,
   input  wire logic         front,
   input  wire key_type      left_key,
   input  wire logic         left_valid,
   input  wire logic         left_le,
   input  wire key_type      right_key,
   input  wire logic         right_valid,
   output key_type           key,
   output logic              valid,
   output logic              le
);

   key_type key_ff, key_in;
   logic    valid_ff, valid_in;

   // new key belongs at or before this cell; the front cell lets equal keys pass
   always_comb begin
      if (!valid_ff) begin
         le = 1'b1;
      end else if (front) begin
         le = new_key > key_ff;
      end else begin
         le = new_key >= key_ff;
      end
   end

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      if (ctl.ins) begin
         if (left_le) begin
            key_in   = left_key;
            valid_in = left_valid;
         end else if (le) begin
            key_in   = new_key;
            valid_in = 1'b1;
         end
      end else if (ctl.rem) begin
         key_in   = right_key;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign key   = key_ff;
   assign valid = valid_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/spq_checker.sv -----
// port-level assertions for the sorted priority queue, with bind
`default_nettype none

module spq_checker
   import spq_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire key_type    rsp_removed_key,
   input wire count_type  rsp_compare_count,
   input wire status_type rsp_status
);

   // every request transaction yields a response on the next cycle
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no response after request transaction");

   // reset drops any pending response
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // empty remove reports -1 and no comparisons
   a_empty_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |->
         rsp_removed_key == KEY_EMPTY && rsp_compare_count == '0)
      else $error("bad payload on empty remove");

   // a stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_removed_key   (rsp_ch.removed_key),
   .rsp_compare_count (rsp_ch.compare_count),
   .rsp_status        (rsp_ch.status)
);

`default_nettype wire
